### rtl/source_text_tokenizer_macros.svh
// Assertion macros for the source text tokenizer checker.
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define STT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Types, codes and helpers shared by the source text tokenizer modules.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int LINE_WIDTH_DEF = 16;
  localparam int LINE_OUT_W     = 16;
  localparam int SLOTS          = 4;
  localparam int SLOT_IDX_W     = 2;
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = 2;
  localparam int QCNT_W         = 3;

  // token classes
  localparam logic [3:0] CLS_WS       = 4'd0;
  localparam logic [3:0] CLS_INT      = 4'd1;
  localparam logic [3:0] CLS_DBL      = 4'd2;
  localparam logic [3:0] CLS_STR      = 4'd3;
  localparam logic [3:0] CLS_IDENT    = 4'd4;
  localparam logic [3:0] CLS_COMMENT  = 4'd5;
  localparam logic [3:0] CLS_DOT      = 4'd6;
  localparam logic [3:0] CLS_DOT_MORE = 4'd7;
  localparam logic [3:0] CLS_ESC      = 4'd8;

  // result kinds
  localparam logic [1:0] K_TEXT = 2'd0;
  localparam logic [1:0] K_END  = 2'd1;
  localparam logic [1:0] K_ERR  = 2'd2;

  // token types
  localparam logic [2:0] TT_INT     = 3'd0;
  localparam logic [2:0] TT_DBL     = 3'd1;
  localparam logic [2:0] TT_STR     = 3'd2;
  localparam logic [2:0] TT_IDENT   = 3'd3;
  localparam logic [2:0] TT_OP      = 3'd4;
  localparam logic [2:0] TT_COMMENT = 3'd5;

  // characters
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_value;
  } in_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [7:0]            out_char;
    logic [2:0]            token_type;
    logic [LINE_OUT_W-1:0] line_number;
    logic                  last;
  } out_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [2:0] typ;
  } slot_t;

  // all results caused by one input beat
  typedef struct packed {
    slot_t [SLOTS-1:0]     slots;
    logic [SLOT_IDX_W-1:0] last_idx;
    logic [LINE_OUT_W-1:0] line;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } qport_t;

  function automatic slot_t mk_slot(logic [1:0] kind, logic [7:0] ch, logic [2:0] typ);
    slot_t s;
    s.kind = kind;
    s.ch   = ch;
    s.typ  = typ;
    return s;
  endfunction

endpackage

### rtl/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// Classifies each input beat, updates token state and builds its result bundle.
// ----------------------------------------------------------------------------
module stt_front #(
  parameter int LINE_WIDTH = stt_pkg::LINE_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  stt_pkg::in_t   in_data,
  output stt_pkg::qport_t push,
  input  logic           push_ready
);

  logic [3:0]            cls_r, cls_nxt;
  logic [LINE_WIDTH-1:0] line_r, line_nxt;
  logic                  err_r, err_nxt;
  logic                  held_r, held_nxt;

  logic [stt_pkg::LINE_OUT_W-1:0]           line_shown;
  stt_pkg::slot_t [stt_pkg::SLOTS-1:0]      slots;
  logic [2:0]                               n;
  logic                                     close_ok;
  logic [2:0]                               close_typ;
  logic                                     accept;

  generate
    if (LINE_WIDTH > stt_pkg::LINE_OUT_W) begin : g_sat
      assign line_shown = (|line_r[LINE_WIDTH-1:stt_pkg::LINE_OUT_W]) ? '1 :
                          line_r[stt_pkg::LINE_OUT_W-1:0];
    end else begin : g_ext
      assign line_shown = stt_pkg::LINE_OUT_W'(line_r);
    end
  endgenerate

  always_comb begin
    close_ok  = 1'b1;
    close_typ = stt_pkg::TT_INT;
    case (cls_r)
      stt_pkg::CLS_INT:      close_typ = stt_pkg::TT_INT;
      stt_pkg::CLS_DBL:      close_typ = stt_pkg::TT_DBL;
      stt_pkg::CLS_DOT_MORE: close_typ = stt_pkg::TT_DBL;
      stt_pkg::CLS_STR:      close_typ = stt_pkg::TT_STR;
      stt_pkg::CLS_ESC:      close_typ = stt_pkg::TT_STR;
      stt_pkg::CLS_IDENT:    close_typ = stt_pkg::TT_IDENT;
      stt_pkg::CLS_COMMENT:  close_typ = stt_pkg::TT_COMMENT;
      stt_pkg::CLS_DOT:      close_typ = stt_pkg::TT_OP;
      default:               close_ok  = 1'b0;
    endcase
  end

  always_comb begin
    logic       flush;
    logic [7:0] c;
    logic       lit;
    logic       skip;
    logic       esc_ok;
    logic [7:0] esc_ch;

    slots    = '0;
    n        = '0;
    cls_nxt  = cls_r;
    line_nxt = line_r;
    err_nxt  = err_r;
    held_nxt = held_r;
    flush    = in_data.cmd;
    c        = in_data.char_value;
    lit      = (cls_r == stt_pkg::CLS_STR) || (cls_r == stt_pkg::CLS_COMMENT);
    skip     = 1'b0;
    esc_ok   = 1'b1;
    esc_ch   = '0;

    case (c)
      stt_pkg::CH_N:   esc_ch = stt_pkg::CH_LF;
      stt_pkg::CH_R:   esc_ch = stt_pkg::CH_CR;
      stt_pkg::CH_T:   esc_ch = stt_pkg::CH_TAB;
      stt_pkg::CH_BSL: esc_ch = stt_pkg::CH_BSL;
      default:         esc_ok = 1'b0;
    endcase

    if (err_r) begin
      slots[0] = stt_pkg::mk_slot(stt_pkg::K_ERR, flush ? 8'h00 : c, stt_pkg::TT_INT);
      n = 3'd1;
    end else begin
      if (held_r) begin
        held_nxt = 1'b0;
        if (!flush && c == stt_pkg::CH_SLASH) begin
          cls_nxt = stt_pkg::CLS_COMMENT;
          skip    = 1'b1;
        end else begin
          slots[0] = stt_pkg::mk_slot(stt_pkg::K_TEXT, stt_pkg::CH_SLASH, stt_pkg::TT_INT);
          slots[1] = stt_pkg::mk_slot(stt_pkg::K_END, 8'h00, stt_pkg::TT_OP);
          n = 3'd2;
        end
      end

      if (!skip) begin
        if (flush) begin
          if (close_ok) begin
            slots[n[1:0]] = stt_pkg::mk_slot(stt_pkg::K_END, 8'h00, close_typ);
            n = n + 3'd1;
          end
          cls_nxt = stt_pkg::CLS_WS;
        end else if (cls_r == stt_pkg::CLS_ESC) begin
          if (esc_ok) begin
            cls_nxt = stt_pkg::CLS_STR;
            slots[n[1:0]] = stt_pkg::mk_slot(stt_pkg::K_TEXT, esc_ch, stt_pkg::TT_INT);
            n = n + 3'd1;
          end else begin
            err_nxt = 1'b1;
            cls_nxt = stt_pkg::CLS_WS;
            slots[n[1:0]] = stt_pkg::mk_slot(stt_pkg::K_ERR, c, stt_pkg::TT_INT);
            n = n + 3'd1;
          end
        end else if (c == stt_pkg::CH_LF || c == stt_pkg::CH_CR) begin
          if (close_ok) begin
            slots[n[1:0]] = stt_pkg::mk_slot(stt_pkg::K_END, 8'h00, close_typ);
            n = n + 3'd1;
          end
          cls_nxt = stt_pkg::CLS_WS;
          if (line_r != '1) begin
            line_nxt = line_r + LINE_WIDTH'(1);
          end
        end else if ((lit && c != stt_pkg::CH_QUOTE && c != stt_pkg::CH_BSL) ||
                     cls_r == stt_pkg::CLS_COMMENT) begin
          slots[n[1:0]] = stt_pkg::mk_slot(stt_pkg::K_TEXT, c, stt_pkg::TT_INT);
          n = n + 3'd1;
        end else if (c >= stt_pkg::CH_0 && c <= stt_pkg::CH_9) begin
          if (cls_r == stt_pkg::CLS_WS) begin
            cls_nxt = stt_pkg::CLS_INT;
          end else if (cls_r == stt_pkg::CLS_DOT) begin
            cls_nxt = stt_pkg::CLS_DBL;
          end
          slots[n[1:0]] = stt_pkg::mk_slot(stt_pkg::K_TEXT, c, stt_pkg::TT_INT);
          n = n + 3'd1;
        end else if (c == stt_pkg::CH_DOT && cls_r == stt_pkg::CLS_WS) begin
          cls_nxt = stt_pkg::CLS_DOT;
          slots[n[1:0]] = stt_pkg::mk_slot(stt_pkg::K_TEXT, c, stt_pkg::TT_INT);
          n = n + 3'd1;
        end else if (c == stt_pkg::CH_DOT && cls_r == stt_pkg::CLS_INT) begin
          cls_nxt = stt_pkg::CLS_DBL;
          slots[n[1:0]] = stt_pkg::mk_slot(stt_pkg::K_TEXT, c, stt_pkg::TT_INT);
          n = n + 3'd1;
        end else if (c inside {stt_pkg::CH_DOT, 8'h7B, 8'h7D, 8'h28, 8'h29, 8'h3D,
                               8'h2D, 8'h2C, 8'h3B} ||
                     (c == stt_pkg::CH_BSL && cls_r != stt_pkg::CLS_STR)) begin
          // single-character operator
          if (close_ok) begin
            slots[n[1:0]] = stt_pkg::mk_slot(stt_pkg::K_END, 8'h00, close_typ);
            n = n + 3'd1;
          end
          cls_nxt = stt_pkg::CLS_WS;
          slots[n[1:0]] = stt_pkg::mk_slot(stt_pkg::K_TEXT, c, stt_pkg::TT_INT);
          n = n + 3'd1;
          slots[n[1:0]] = stt_pkg::mk_slot(stt_pkg::K_END, 8'h00, stt_pkg::TT_OP);
          n = n + 3'd1;
        end else if (c == stt_pkg::CH_BSL) begin
          cls_nxt = stt_pkg::CLS_ESC;
        end else if (c == stt_pkg::CH_SPACE || c == stt_pkg::CH_TAB ||
                     c == stt_pkg::CH_QUOTE || c == stt_pkg::CH_SLASH) begin
          if (close_ok) begin
            slots[n[1:0]] = stt_pkg::mk_slot(stt_pkg::K_END, 8'h00, close_typ);
            n = n + 3'd1;
          end
          cls_nxt = stt_pkg::CLS_WS;
          if (c == stt_pkg::CH_QUOTE && cls_r != stt_pkg::CLS_STR) begin
            cls_nxt = stt_pkg::CLS_STR;
            slots[n[1:0]] = stt_pkg::mk_slot(stt_pkg::K_TEXT, c, stt_pkg::TT_INT);
            n = n + 3'd1;
          end
          if (c == stt_pkg::CH_SLASH) begin
            held_nxt = 1'b1;
          end
        end else begin
          if (cls_r == stt_pkg::CLS_WS || cls_r == stt_pkg::CLS_INT ||
              cls_r == stt_pkg::CLS_DBL) begin
            if (close_ok) begin
              slots[n[1:0]] = stt_pkg::mk_slot(stt_pkg::K_END, 8'h00, close_typ);
              n = n + 3'd1;
            end
            cls_nxt = stt_pkg::CLS_IDENT;
          end else if (cls_r == stt_pkg::CLS_DOT) begin
            cls_nxt = stt_pkg::CLS_DOT_MORE;
          end
          slots[n[1:0]] = stt_pkg::mk_slot(stt_pkg::K_TEXT, c, stt_pkg::TT_INT);
          n = n + 3'd1;
        end
      end
    end
  end

  assign in_ready            = push_ready;
  assign accept              = in_valid && in_ready;
  assign push.valid          = in_valid && (n != 3'd0);
  assign push.bundle.slots   = slots;
  assign push.bundle.last_idx = stt_pkg::SLOT_IDX_W'(n - 3'd1);
  assign push.bundle.line    = line_shown;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r  <= stt_pkg::CLS_WS;
      line_r <= LINE_WIDTH'(1);
      err_r  <= 1'b0;
      held_r <= 1'b0;
    end else if (accept) begin
      cls_r  <= cls_nxt;
      line_r <= line_nxt;
      err_r  <= err_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

### rtl/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// Short FIFO of result bundles between the front and back parts.
// ----------------------------------------------------------------------------
module stt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  stt_pkg::qport_t push,
  output logic            push_ready,
  output stt_pkg::qport_t head,
  input  logic            pop
);

  stt_pkg::bundle_t                  mem_r [stt_pkg::QDEPTH];
  logic [stt_pkg::QPTR_W-1:0]        wr_r, wr_nxt;
  logic [stt_pkg::QPTR_W-1:0]        rd_r, rd_nxt;
  logic [stt_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;
  logic                              do_push;
  logic                              do_pop;

  assign push_ready  = (cnt_r != stt_pkg::QCNT_W'(stt_pkg::QDEPTH));
  assign do_push     = push.valid && push_ready;
  assign do_pop      = pop && (cnt_r != '0);
  assign head.valid  = (cnt_r != '0);
  assign head.bundle = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push.bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back
// Walks the head bundle one result per cycle into the output register, unless the output is stalled.
// ----------------------------------------------------------------------------
module stt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  stt_pkg::qport_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output stt_pkg::out_t   out_data
);

  logic [stt_pkg::SLOT_IDX_W-1:0] idx_r, idx_nxt;
  logic                           out_valid_r, out_valid_nxt;
  stt_pkg::out_t                  out_data_r, out_data_nxt;
  stt_pkg::slot_t                 cur;
  logic                           is_last;
  logic                           load;

  assign cur     = head.bundle.slots[idx_r];
  assign is_last = (idx_r == head.bundle.last_idx);
  assign load    = head.valid && (!out_valid_r || out_ready);
  assign pop     = load && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (load) begin
      idx_nxt                  = is_last ? '0 : idx_r + 1'b1;
      out_valid_nxt            = 1'b1;
      out_data_nxt.kind        = cur.kind;
      out_data_nxt.out_char    = cur.ch;
      out_data_nxt.token_type  = cur.typ;
      out_data_nxt.line_number = (cur.kind == stt_pkg::K_TEXT) ? '0 : head.bundle.line;
      out_data_nxt.last        = is_last;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming tokenizer: one source byte or flush command in, token text and
// token-end beats out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per source byte (cmd 0) or flush of the open token (cmd 1).
//   out_* : result beats - token text character, token end with type and line,
//           or escape error. The final beat caused by an input carries last.
//   An input beat may cause no result (e.g. a held '/', a space, a backslash inside a string).
// Throughput: the front takes one input beat per cycle while its bundle queue
//   (4 entries) has room; the back sends one result per cycle while results
//   are queued and out_ready is high. An input causes 0 to 4 results.
// Path: an accepted input's bundle is written into the queue, and its results
//   are then loaded one at a time into the output register and presented
//   from there.
// Reset (rst_n low, synchronous): no open token, line count one, error cleared,
//   queue and output emptied.
// Stall: while out_ready is low the output beat holds; the queue fills and then
//   in_ready drops until results drain.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
  parameter int LINE_WIDTH = stt_pkg::LINE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  stt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output stt_pkg::out_t out_data
);

  stt_pkg::qport_t push;
  stt_pkg::qport_t head;
  logic            push_ready;
  logic            pop;

  stt_front #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_ready(push_ready)
  );

  stt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ready(push_ready),
    .head      (head),
    .pop       (pop)
  );

  stt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

### rtl/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks on the tokenizer's input and result channels.
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_macros.svh"

module stt_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input stt_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input stt_pkg::out_t out_data
);

  logic in_take;
  logic out_stall;
  logic out_text;
  logic out_tail;
  logic out_err;
  logic text_clean;

  assign in_take    = in_valid && in_ready;
  assign out_stall  = out_valid && !out_ready;
  assign out_text   = out_valid && (out_data.kind == stt_pkg::K_TEXT);
  assign out_tail   = out_valid && (out_data.kind != stt_pkg::K_TEXT);
  assign out_err    = out_valid && (out_data.kind == stt_pkg::K_ERR);
  assign text_clean = (out_data.line_number == '0) &&
                      (out_data.token_type == stt_pkg::TT_INT);

  `STT_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "stalled beat moved")
  `STT_ASSERT_IMPL(a_text_clean, out_text, text_clean, "text beat carries type or line")
  `STT_ASSERT_IMPL(a_line_nonzero, out_tail, out_data.line_number != '0, "beat without line")
  `STT_ASSERT_IMPL(a_err_last, out_err, out_data.last, "error beat not last")
  `STT_ASSERT_IMPL(a_in_known, in_take, !$isunknown(in_data), "accepted beat has unknown data")

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);
